[sv/lru_pkg.sv]
// shared types, constants and a helper function for the lehmer128 random unit
// no dependencies; imported by the controller, datapath and top level
package lru_pkg;

  // fixed lehmer multiplier
  localparam logic [63:0] LRU_MULT = 64'hda942042e4dd58b5;

  // request command codes
  localparam logic [2:0] CMD_RAW64  = 3'd0;
  localparam logic [2:0] CMD_LOW31  = 3'd1;
  localparam logic [2:0] CMD_LOW32  = 3'd2;
  localparam logic [2:0] CMD_RANGE  = 3'd3;
  localparam logic [2:0] CMD_CHANCE = 3'd4;

  // sequencing lengths
  localparam int unsigned MUL_STEPS = 7;
  localparam int unsigned DIV_STEPS = 64;
  localparam logic [5:0]  MUL_LAST  = 6'(MUL_STEPS - 1);
  localparam logic [5:0]  DIV_LAST  = 6'(DIV_STEPS - 1);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_COMMIT,
    ST_DIV,
    ST_WRITE
  } lru_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       commit;
    logic       div_step;
    logic       out_load;
  } lru_dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_div;
  } lru_sts_t;

  // one partial product: state limb, multiplier limb, limb shift
  typedef struct packed {
    logic [1:0] s_limb;
    logic       m_limb;
    logic [1:0] shift;
  } lru_pp_t;

  // partial products of state * mult that land below bit 128
  function automatic lru_pp_t lru_pp_sel(input logic [2:0] step);
    lru_pp_t pp;
    unique case (step)
      3'd0:    pp = '{s_limb: 2'd0, m_limb: 1'b0, shift: 2'd0};
      3'd1:    pp = '{s_limb: 2'd1, m_limb: 1'b0, shift: 2'd1};
      3'd2:    pp = '{s_limb: 2'd0, m_limb: 1'b1, shift: 2'd1};
      3'd3:    pp = '{s_limb: 2'd2, m_limb: 1'b0, shift: 2'd2};
      3'd4:    pp = '{s_limb: 2'd1, m_limb: 1'b1, shift: 2'd2};
      3'd5:    pp = '{s_limb: 2'd3, m_limb: 1'b0, shift: 2'd3};
      3'd6:    pp = '{s_limb: 2'd2, m_limb: 1'b1, shift: 2'd3};
      default: pp = '{s_limb: 2'd0, m_limb: 1'b0, shift: 2'd0};
    endcase
    return pp;
  endfunction

endpackage

[sv/lru_ctrl.sv]
// controller state machine for the lehmer128 random unit
// depends on lru_pkg; drives the datapath through lru_dp_cmd_t
module lru_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  lru_pkg::lru_sts_t    sts,
  output lru_pkg::lru_dp_cmd_t cmd
);
  import lru_pkg::*;

  lru_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign in_take  = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    if (cnt_r == MUL_LAST) state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = sts.need_div ? ST_DIV : ST_WRITE;
      ST_DIV:    if (cnt_r == DIV_LAST) state_nxt = ST_WRITE;
      ST_WRITE:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // step counter for multiply and divide sequences
  always_comb begin
    cnt_nxt = '0;
    if (state_r == ST_MUL) begin
      cnt_nxt = (cnt_r == MUL_LAST) ? '0 : cnt_r + 6'd1;
    end else if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_take;
    cmd.mul_en   = (state_r == ST_MUL);
    cmd.mul_step = cnt_r[2:0];
    cmd.commit   = (state_r == ST_COMMIT);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_WRITE) && out_free;
  end

  // output valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a taken request blocks further requests until it is finished
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // multiply step count stays inside the partial product table
  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> cnt_r <= MUL_LAST)
    else $error("multiply step out of range");

  // a result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten");

  // the divider runs its full length then hands over to the write
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && cnt_r == DIV_LAST |=> state_r == ST_WRITE)
    else $error("divide sequence ended wrongly");
`endif

endmodule

[sv/lru_dpath.sv]
// datapath for the lehmer128 random unit: state, shared 32x32 multiplier,
// radix-2 remainder unit and result registers; depends on lru_pkg
module lru_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic [2:0]           in_cmd,
  input  logic signed [31:0]   in_range_lower,
  input  logic signed [31:0]   in_range_upper,
  input  logic [31:0]          in_odds_numerator,
  input  logic [31:0]          in_odds_denominator,
  input  lru_pkg::lru_dp_cmd_t cmd,
  output lru_pkg::lru_sts_t    sts,
  output logic [63:0]          out_draw_value,
  output logic signed [31:0]   out_ranged_value,
  output logic                 out_hit
);
  import lru_pkg::*;

  logic [127:0] st_r, st_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  p_r;
  logic [1:0]   sh_r;
  logic         pv_r;
  logic [2:0]   cmd_r;
  logic [31:0]  lower_r, upper_r, numer_r, denom_r;
  logic [63:0]  dvd_r;
  logic [31:0]  rem_r;
  logic [31:0]  div_d_r;
  logic [63:0]  draw_r, draw_nxt;
  logic [31:0]  ranged_r, ranged_nxt;
  logic         hit_r, hit_nxt;

  lru_pp_t      pp;
  logic [31:0]  s_limb, m_limb;
  logic [127:0] pp_ext;
  logic [32:0]  rem_sh;
  logic [31:0]  span;
  logic [63:0]  draw;
  logic [31:0]  q;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      lower_r <= 32'(unsigned'(in_range_lower));
      upper_r <= 32'(unsigned'(in_range_upper));
      numer_r <= in_odds_numerator;
      denom_r <= in_odds_denominator;
    end
  end

  assign sts.need_div = (cmd_r == CMD_RANGE) || (cmd_r == CMD_CHANCE);

  // limb selection for the shared multiplier
  always_comb begin
    pp = lru_pp_sel(cmd.mul_step);
    unique case (pp.s_limb)
      2'd0:    s_limb = st_r[31:0];
      2'd1:    s_limb = st_r[63:32];
      2'd2:    s_limb = st_r[95:64];
      default: s_limb = st_r[127:96];
    endcase
    m_limb = pp.m_limb ? LRU_MULT[63:32] : LRU_MULT[31:0];
  end

  // registered partial product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r  <= 64'(s_limb) * 64'(m_limb);
      sh_r <= pp.shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_en;
    end
  end

  // accumulate shifted partial products modulo 2^128
  assign pp_ext = 128'(p_r) << {sh_r, 5'd0};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.capture) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + pp_ext;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // generator state: seed load or commit of the new product
  always_comb begin
    st_nxt = st_r;
    if (cfg_wr_en) begin
      st_nxt = {96'd0, cfg_wr_data};
    end else if (cmd.commit) begin
      st_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= 128'd1;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign draw = st_r[127:64];
  assign span = upper_r - lower_r + 32'd1;

  // radix-2 remainder, one dividend bit per step
  assign rem_sh = {rem_r, dvd_r[63]};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      dvd_r   <= (cmd_r == CMD_RANGE) ? {32'd0, acc_r[95:64]} : acc_r[127:64];
      div_d_r <= (cmd_r == CMD_RANGE) ? span : denom_r;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      if (rem_sh >= {1'b0, div_d_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, div_d_r});
      end else begin
        rem_r <= rem_sh[31:0];
      end
    end
  end

  // range result: full span passes the draw through
  assign q = (span == 32'd0) ? draw[31:0] : rem_r;

  // result selection by mode, fields the mode does not produce read zero
  always_comb begin
    draw_nxt   = '0;
    ranged_nxt = '0;
    hit_nxt    = 1'b0;
    unique case (cmd_r)
      CMD_RAW64:  draw_nxt   = draw;
      CMD_LOW31:  draw_nxt   = {33'd0, draw[30:0]};
      CMD_LOW32:  draw_nxt   = {32'd0, draw[31:0]};
      CMD_RANGE:  ranged_nxt = q + lower_r;
      CMD_CHANCE: hit_nxt    = (denom_r != 32'd0) && (rem_r < numer_r);
      default:    draw_nxt   = draw;
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      draw_r   <= draw_nxt;
      ranged_r <= ranged_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign out_draw_value   = draw_r;
  assign out_ranged_value = signed'(ranged_r);
  assign out_hit          = hit_r;

endmodule

[sv/lehmer128_random_unit_core.sv]
// lehmer128 random unit: 128-bit multiplicative congruential generator
// top level joining lru_ctrl and lru_dpath; depends on lru_pkg
//
// usage:
//  - input channel (in_valid / in_stall) carries one request: in_cmd picks
//    raw 64-bit, low 31, low 32, inclusive signed range or chance test
//  - each request advances the state once and yields exactly one result on
//    the output channel (out_valid / out_stall); unused fields read zero
//  - cfg_wr_en with cfg_wr_data reloads the state (seed in the low word);
//    write only while no request is in flight
//  - raw and masked modes run multiply, accumulate, commit and write;
//    range and chance modes add the remainder steps before the write; the
//    next request can be taken in the cycle after the result is loaded, so
//    requests are worked on one at a time
//  - the state update uses one 32x32 multiplier over 7 partial products;
//    range and chance modes add a radix-2 remainder of 64 steps
//  - a result held by out_stall stays stable; a further request may still
//    be worked on, and its result waits until the held one is taken
//  - reset (rst_n low, synchronous) loads the state with 1, drops any
//    request in flight and clears out_valid
module lehmer128_random_unit_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_range_lower,
  input  logic signed [31:0] in_range_upper,
  input  logic [31:0]        in_odds_numerator,
  input  logic [31:0]        in_odds_denominator,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_draw_value,
  output logic signed [31:0] out_ranged_value,
  output logic               out_hit
);
  import lru_pkg::*;

  lru_dp_cmd_t dp_cmd;
  lru_sts_t    dp_sts;

  // sequencing
  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // arithmetic and storage
  lru_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_cmd              (in_cmd),
    .in_range_lower      (in_range_lower),
    .in_range_upper      (in_range_upper),
    .in_odds_numerator   (in_odds_numerator),
    .in_odds_denominator (in_odds_denominator),
    .cmd                 (dp_cmd),
    .sts                 (dp_sts),
    .out_draw_value      (out_draw_value),
    .out_ranged_value    (out_ranged_value),
    .out_hit             (out_hit)
  );

endmodule

[dv/lehmer128_random_unit_core_test.sv]
// self-checking bench for the lehmer128 random unit: directed and random requests
// under random idling, with a scoreboard class that tracks the 128-bit state
// depends on lru_pkg and lehmer128_random_unit_core
module lehmer128_random_unit_core_test;
  import lru_pkg::*;

  // spare command codes, still advance the state and return the raw draw
  localparam logic [2:0] CMD_SPARE_LO = CMD_CHANCE + 3'd1;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;

  // scoreboard: own copy of the generator state plus the draws still owed
  class draw_scoreboard;
    typedef struct {
      logic [63:0] draw;
      logic [31:0] ranged;
      logic        hit;
    } draw_result_t;

    logic [127:0] lehmer_state;
    draw_result_t pending_draws[$];
    int unsigned  errors;

    function new();
      errors = 0;
      load_seed(32'd1);
    endfunction

    function void load_seed(logic [31:0] seed);
      lehmer_state = {96'd0, seed};
    endfunction

    // advance the state once and queue the result this request must give
    function void note_request(logic [2:0] cmd, logic [31:0] lower, logic [31:0] upper,
                               logic [31:0] numer, logic [31:0] denom);
      draw_result_t res;
      logic [63:0]  draw;
      logic [31:0]  span;
      logic [31:0]  folded;
      res = '{draw: 64'd0, ranged: 32'd0, hit: 1'b0};
      lehmer_state = lehmer_state * LRU_MULT;
      draw = lehmer_state[127:64];
      case (cmd)
        CMD_RAW64: res.draw = draw;
        CMD_LOW31: res.draw = {33'd0, draw[30:0]};
        CMD_LOW32: res.draw = {32'd0, draw[31:0]};
        CMD_RANGE: begin
          // span wraps to zero on a full range, then the draw passes untouched
          span = upper - lower + 32'd1;
          folded = (span == 32'd0) ? draw[31:0] : draw[31:0] % span;
          res.ranged = folded + lower;
        end
        CMD_CHANCE: begin
          if (denom != 32'd0) res.hit = (draw % {32'd0, denom}) < {32'd0, numer};
        end
        default: res.draw = draw;
      endcase
      pending_draws.push_back(res);
    endfunction

    // compare one delivered result with the oldest one owed
    function void check_result(logic [63:0] draw, logic [31:0] ranged, logic hit);
      draw_result_t exp_res;
      if (pending_draws.size() == 0) begin
        errors++;
        $display("%0t: result with no request owed: draw %h ranged %h hit %b",
                 $time, draw, ranged, hit);
        return;
      end
      exp_res = pending_draws.pop_front();
      if (draw !== exp_res.draw) begin
        errors++;
        $display("%0t: draw_value expected %h got %h", $time, exp_res.draw, draw);
      end
      if (ranged !== exp_res.ranged) begin
        errors++;
        $display("%0t: ranged_value expected %h got %h", $time, exp_res.ranged, ranged);
      end
      if (hit !== exp_res.hit) begin
        errors++;
        $display("%0t: hit expected %b got %b", $time, exp_res.hit, hit);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_cmd;
  logic signed [31:0] in_range_lower;
  logic signed [31:0] in_range_upper;
  logic [31:0]        in_odds_numerator;
  logic [31:0]        in_odds_denominator;
  logic               out_valid;
  logic               out_stall;
  logic [63:0]        out_draw_value;
  logic signed [31:0] out_ranged_value;
  logic               out_hit;

  draw_scoreboard board = new();
  bit             steady;
  int unsigned    holds_asked;
  int unsigned    quiet_cycles;

  lehmer128_random_unit_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_range_lower      (in_range_lower),
    .in_range_upper      (in_range_upper),
    .in_odds_numerator   (in_odds_numerator),
    .in_odds_denominator (in_odds_denominator),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_draw_value      (out_draw_value),
    .out_ranged_value    (out_ranged_value),
    .out_hit             (out_hit)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // offer one request, hold it until taken, then maybe idle a while
  task automatic send_request(logic [2:0] cmd, logic [31:0] lower, logic [31:0] upper,
                              logic [31:0] numer, logic [31:0] denom);
    int unsigned gap;
    in_valid            <= 1'b1;
    in_cmd              <= cmd;
    in_range_lower      <= lower;
    in_range_upper      <= upper;
    in_odds_numerator   <= numer;
    in_odds_denominator <= denom;
    do @(posedge clk); while (in_stall);
    board.note_request(cmd, lower, upper, numer, denom);
    if (!steady && $urandom_range(0, 99) < 27) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 90) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random request, mostly well-formed for its mode, every field still random
  task automatic random_request();
    int unsigned pick;
    logic [2:0]  cmd;
    logic [31:0] lower;
    logic [31:0] upper;
    logic [31:0] numer;
    logic [31:0] denom;
    pick = $urandom_range(0, 99);
    if (pick < 12) cmd = CMD_RAW64;
    else if (pick < 22) cmd = CMD_LOW31;
    else if (pick < 32) cmd = CMD_LOW32;
    else if (pick < 64) cmd = CMD_RANGE;
    else if (pick < 94) cmd = CMD_CHANCE;
    else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    lower = $urandom;
    case ($urandom_range(0, 3))
      0: upper = $urandom;
      1: upper = lower + $urandom_range(0, 15);
      2: upper = lower + $urandom_range(0, 65535);
      default: upper = lower + ALL_ONES;
    endcase
    case ($urandom_range(0, 2))
      0: denom = $urandom_range(0, 7);
      1: denom = $urandom;
      default: denom = $urandom >> $urandom_range(0, 31);
    endcase
    numer = $urandom_range(0, 1) ? $urandom : $urandom_range(0, denom);
    send_request(cmd, lower, upper, numer, denom);
  endtask

  // drop valid and wait until every owed result has been delivered
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_draws.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] seed);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.load_seed(seed);
  endtask

  // one seed setting followed by a run of random requests
  task automatic run_phase(logic [31:0] seed, int unsigned count, bit calm, bit hold);
    settle();
    write_seed(seed);
    steady <= calm;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold && i == 5) holds_asked <= holds_asked + 1;
      random_request();
    end
  endtask

  // edge cases of each mode under the reset seed
  task automatic directed_requests();
    send_request(CMD_RAW64, 32'd0, 32'd0, 32'd0, 32'd0);
    send_request(CMD_LOW31, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(CMD_LOW32, INT_MIN, INT_MAX, 32'd0, ALL_ONES);
    // single-value span
    send_request(CMD_RANGE, 32'd0, 32'd0, 32'd0, 32'd0);
    // full range wraps the span to zero
    send_request(CMD_RANGE, INT_MIN, INT_MAX, ALL_ONES, ALL_ONES);
    send_request(CMD_RANGE, 32'd0, ALL_ONES, 32'd0, 32'd0);
    send_request(CMD_RANGE, INT_MIN, INT_MIN, 32'd0, 32'd0);
    send_request(CMD_RANGE, INT_MAX, INT_MAX, 32'd0, 32'd0);
    send_request(CMD_RANGE, -32'sd10, 32'sd10, 32'd0, 32'd0);
    // reversed bounds
    send_request(CMD_RANGE, 32'sd100, -32'sd100, 32'd0, 32'd0);
    send_request(CMD_RANGE, INT_MAX, INT_MIN, 32'd0, 32'd0);
    // zero denominator never hits
    send_request(CMD_CHANCE, 32'd0, 32'd0, ALL_ONES, 32'd0);
    send_request(CMD_CHANCE, 32'd0, 32'd0, 32'd0, 32'd1);
    send_request(CMD_CHANCE, 32'd0, 32'd0, 32'd1, 32'd1);
    send_request(CMD_CHANCE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(CMD_CHANCE, 32'd0, 32'd0, 32'd0, ALL_ONES);
    send_request(CMD_CHANCE, 32'd0, 32'd0, 32'd2, 32'd3);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send_request(3'(c), ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin : receiver
    int unsigned holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < 27);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_draw_value, out_ranged_value, out_hit);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 32'd0;
    in_valid            <= 1'b0;
    in_cmd              <= CMD_RAW64;
    in_range_lower      <= 32'd0;
    in_range_upper      <= 32'd0;
    in_odds_numerator   <= 32'd0;
    in_odds_denominator <= 32'd0;
    steady              <= 1'b0;
    holds_asked         <= 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();
    // zero seed keeps every draw at zero
    run_phase(32'd0, 30, 1'b0, 1'b0);
    run_phase(ALL_ONES, 200, 1'b0, 1'b0);
    run_phase($urandom, 400, 1'b1, 1'b0);
    run_phase($urandom, 400, 1'b0, 1'b1);
    run_phase(INT_MIN, 300, 1'b0, 1'b0);
    run_phase(32'd1, 300, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
